[hdl/wltt_pkg.sv]
// Shared constants for the windowed loss trend tracker.
// No dependencies; compile first.
package wltt_pkg;

	localparam int Q_W      = 24;   // Q8.16 sample and mean width
	localparam int MIN_W    = 7;    // ready threshold register width
	localparam int DIV_W    = 40;   // widest dividend: recent mean << 16
	localparam int DVS_W    = 25;   // widest divisor: overall mean + 1
	localparam int DCNT_W   = 6;    // holds DIV_W

	localparam logic [Q_W-1:0]   ONE_Q16    = 24'h010000;
	localparam logic [Q_W-1:0]   MEAN_SAT   = 24'hFFFFFF;
	localparam logic [MIN_W-1:0] MIN_RESET  = 7'd10;

endpackage

[hdl/wltt_ifs.sv]
// Handshake channels of the windowed loss trend tracker: sample in,
// result out and the ready threshold write port. Depends on wltt_pkg.
interface wltt_in_if import wltt_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [Q_W-1:0] loss_value;
	logic           loss_finite;

	modport source (output valid, loss_value, loss_finite, input ready);
	modport sink   (input valid, loss_value, loss_finite, output ready);
endinterface

interface wltt_out_if import wltt_pkg::*; #(parameter int CNT_W = 7) ();
	logic             valid;
	logic             ready;
	logic [Q_W-1:0]   trend_ratio;
	logic             ready_res;
	logic [Q_W-1:0]   recent_mean;
	logic [Q_W-1:0]   overall_mean;
	logic [CNT_W-1:0] stored_count;

	modport source (output valid, trend_ratio, ready_res, recent_mean, overall_mean,
		stored_count, input ready);
	modport sink   (input valid, trend_ratio, ready_res, recent_mean, overall_mean,
		stored_count, output ready);
endinterface

interface wltt_cfg_if import wltt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MIN_W-1:0] min_count;

	modport source (output valid, min_count, input ready);
	modport sink   (input valid, min_count, output ready);
endinterface

[hdl/windowed_loss_trend_tracker.sv]
// Windowed loss trend tracker top level: sample ring, window sum, recent
// walk and a shared bit-serial divider. Depends on wltt_pkg and wltt_ifs.
//
// One loss word in, one result word out. A finite sample goes into a ring of
// the last WINDOW_DEPTH samples (the oldest is subtracted from the running
// sum once the ring is full); then the newest k = max(1, min(n/4, RECENT_CAP))
// entries are read back one per cycle from the ring's single read port and
// summed, and a restoring divider that yields one quotient bit per cycle
// forms recent = rsum/k, overall = sum/n and, when ready, the trend
// (recent << 16)/(overall + 1), saturated. A non-finite sample only re-forms
// the trend from the held means. The divider sets the item time: a finite
// item runs ST_RD_OLD, ST_SUB (only when the ring is full), ST_WRITE,
// ST_WALK, ST_LOAD/ST_DIV/ST_STORE for recent and then for overall, and
// ST_TREND, plus the trend division when ready; a non-finite item starts at
// ST_TREND. ST_OUT waits for the result register to empty. One item is
// worked at a time; the result sits in an output register so the next sample
// can be taken while the previous result waits. The ready threshold is taken
// only while the block is idle with no result word waiting, and a pending
// threshold write takes that cycle ahead of a sample.
module windowed_loss_trend_tracker import wltt_pkg::*; #(
	parameter int WINDOW_DEPTH = 64,
	parameter int RECENT_CAP   = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	wltt_in_if.sink   sample,
	wltt_out_if.source result,
	wltt_cfg_if.sink  cfg
);

	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int AW     = $clog2(WINDOW_DEPTH);
	localparam int SUM_W  = Q_W + $clog2(WINDOW_DEPTH);
	localparam int K_W    = $clog2(RECENT_CAP + 1);
	localparam int RSUM_W = Q_W + K_W;
	localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_OLD, ST_SUB, ST_WRITE, ST_WALK,
		ST_LOAD, ST_DIV, ST_STORE, ST_TREND, ST_OUT
	} state_t;

	typedef enum logic [1:0] {OP_RECENT, OP_OVERALL, OP_RATIO} div_op_t;

	state_t           state_q;
	div_op_t          op_q;
	logic [Q_W-1:0]   smp_q;
	logic [AW-1:0]    slot_q;
	logic [AW-1:0]    ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [SUM_W-1:0] sum_q;
	logic [K_W-1:0]   iss_q;
	logic             rd_vld_s1;
	logic [RSUM_W-1:0] acc_q;
	logic [Q_W-1:0]   recent_q;
	logic [Q_W-1:0]   overall_q;
	logic [Q_W-1:0]   trend_q;
	logic [MIN_W-1:0] min_q;

	// divider
	logic [DIV_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DCNT_W-1:0] dcnt_q;

	// result register
	logic             out_vld_q;
	logic [Q_W-1:0]   out_trend_q;
	logic             out_rdy_q;
	logic [Q_W-1:0]   out_recent_q;
	logic [Q_W-1:0]   out_overall_q;
	logic [CNT_W-1:0] out_count_q;
	logic             out_load;

	// sample ring
	logic [Q_W-1:0] ring [WINDOW_DEPTH];
	logic [Q_W-1:0] rd_data_q;
	logic [AW-1:0]  rd_addr;
	logic           ring_we;

	logic [31:0]    quarter;
	logic [K_W-1:0] k_cnt;
	logic           full;
	logic           ready_now;
	logic           issue;
	logic [DVS_W:0] shifted;
	logic [DVS_W+1:0] trial;
	logic           ge;

	// k = max(1, min(n/4, RECENT_CAP))
	always_comb begin
		quarter = 32'(fill_q) >> 2;
		if (quarter > 32'(RECENT_CAP)) begin
			k_cnt = K_W'(RECENT_CAP);
		end else if (quarter == 32'd0) begin
			k_cnt = K_W'(1);
		end else begin
			k_cnt = K_W'(quarter);
		end
	end

	assign full      = (fill_q == CNT_W'(WINDOW_DEPTH));
	assign ready_now = (CMP_W'(fill_q) >= CMP_W'(min_q));
	assign issue     = (state_q == ST_WALK) && (iss_q != k_cnt);
	assign rd_addr   = (state_q == ST_RD_OLD) ? slot_q : ptr_q;
	assign ring_we   = (state_q == ST_WRITE);

	// one restoring step: shift in the next dividend bit, trial subtract
	assign shifted = {rem_q, dvd_q[DIV_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = !trial[DVS_W+1];

	// a threshold write waits for an empty block and then wins the idle cycle
	assign sample.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign cfg.ready    = (state_q == ST_IDLE) && !out_vld_q;

	// load the result register once it is free
	assign out_load = (state_q == ST_OUT) && (!out_vld_q || result.ready);

	assign result.valid        = out_vld_q;
	assign result.trend_ratio  = out_trend_q;
	assign result.ready_res    = out_rdy_q;
	assign result.recent_mean  = out_recent_q;
	assign result.overall_mean = out_overall_q;
	assign result.stored_count = out_count_q;

	// Ring storage: single write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[slot_q] <= smp_q;
		end
		rd_data_q <= ring[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			op_q          <= OP_RECENT;
			smp_q         <= '0;
			slot_q        <= '0;
			ptr_q         <= '0;
			fill_q        <= '0;
			sum_q         <= '0;
			iss_q         <= '0;
			rd_vld_s1     <= 1'b0;
			acc_q         <= '0;
			recent_q      <= '0;
			overall_q     <= '0;
			trend_q       <= '0;
			min_q         <= MIN_RESET;
			dvd_q         <= '0;
			dvs_q         <= '0;
			rem_q         <= '0;
			quo_q         <= '0;
			dcnt_q        <= '0;
			out_vld_q     <= 1'b0;
			out_trend_q   <= '0;
			out_rdy_q     <= 1'b0;
			out_recent_q  <= '0;
			out_overall_q <= '0;
			out_count_q   <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				min_q <= cfg.min_count;
			end

			// raise the result word on a load, drop it once the sink takes it
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && result.ready) begin
				out_vld_q <= 1'b0;
			end

			rd_vld_s1 <= issue;

			case (state_q)
				ST_IDLE: begin
					if (sample.valid && sample.ready) begin
						smp_q <= sample.loss_value;
						if (!sample.loss_finite) begin
							state_q <= ST_TREND;
						end else if (full) begin
							state_q <= ST_RD_OLD;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end

				// fetch the oldest sample so it can leave the sum
				ST_RD_OLD: begin
					state_q <= ST_SUB;
				end

				ST_SUB: begin
					sum_q   <= sum_q - SUM_W'(rd_data_q);
					state_q <= ST_WRITE;
				end

				// store the sample, advance the slot, start the walk at the newest
				ST_WRITE: begin
					sum_q <= sum_q + SUM_W'(smp_q);
					if (!full) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					slot_q  <= (slot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + AW'(1);
					ptr_q   <= slot_q;
					iss_q   <= '0;
					acc_q   <= '0;
					state_q <= ST_WALK;
				end

				// read back the newest k entries, one per cycle, oldest last
				ST_WALK: begin
					if (issue) begin
						iss_q <= iss_q + K_W'(1);
						ptr_q <= (ptr_q == '0) ? AW'(WINDOW_DEPTH - 1) : ptr_q - AW'(1);
					end
					if (rd_vld_s1) begin
						acc_q <= acc_q + RSUM_W'(rd_data_q);
					end
					if (!issue && !rd_vld_s1) begin
						op_q    <= OP_RECENT;
						state_q <= ST_LOAD;
					end
				end

				// left-align the dividend so only its real bits are walked
				ST_LOAD: begin
					rem_q <= '0;
					quo_q <= '0;
					case (op_q)
						OP_RECENT: begin
							dvd_q  <= {acc_q, {(DIV_W - RSUM_W){1'b0}}};
							dvs_q  <= DVS_W'(k_cnt);
							dcnt_q <= DCNT_W'(RSUM_W);
						end
						OP_OVERALL: begin
							dvd_q  <= {sum_q, {(DIV_W - SUM_W){1'b0}}};
							dvs_q  <= DVS_W'(fill_q);
							dcnt_q <= DCNT_W'(SUM_W);
						end
						default: begin
							dvd_q  <= {recent_q, 16'h0000};
							dvs_q  <= {1'b0, overall_q} + DVS_W'(1);
							dcnt_q <= DCNT_W'(DIV_W);
						end
					endcase
					state_q <= ST_DIV;
				end

				ST_DIV: begin
					dvd_q  <= dvd_q << 1;
					quo_q  <= {quo_q[DIV_W-2:0], ge};
					rem_q  <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
					dcnt_q <= dcnt_q - DCNT_W'(1);
					if (dcnt_q == DCNT_W'(1)) begin
						state_q <= ST_STORE;
					end
				end

				ST_STORE: begin
					case (op_q)
						OP_RECENT: begin
							recent_q <= quo_q[Q_W-1:0];
							op_q     <= OP_OVERALL;
							state_q  <= ST_LOAD;
						end
						OP_OVERALL: begin
							overall_q <= quo_q[Q_W-1:0];
							state_q   <= ST_TREND;
						end
						default: begin
							trend_q <= (quo_q[DIV_W-1:Q_W] != '0) ? MEAN_SAT : quo_q[Q_W-1:0];
							state_q <= ST_OUT;
						end
					endcase
				end

				// the ratio only counts once enough samples are held
				ST_TREND: begin
					if (ready_now) begin
						op_q    <= OP_RATIO;
						state_q <= ST_LOAD;
					end else begin
						trend_q <= ONE_Q16;
						state_q <= ST_OUT;
					end
				end

				// hold until the result register is free
				ST_OUT: begin
					if (out_load) begin
						out_trend_q   <= trend_q;
						out_rdy_q     <= ready_now;
						out_recent_q  <= recent_q;
						out_overall_q <= overall_q;
						out_count_q   <= fill_q;
						state_q       <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/wltt_check.sv]
// Port-level checker for the windowed loss trend tracker, and its bind.
// Depends on wltt_pkg and on the top level's port names.
module wltt_check import wltt_pkg::*; #(
	parameter int WINDOW_DEPTH = 64,
	parameter int CNT_W        = 7
) (
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic [MIN_W-1:0] cfg_min_count,
	input logic             res_valid,
	input logic             res_ready,
	input logic [Q_W-1:0]   trend_ratio,
	input logic             ready_res,
	input logic [Q_W-1:0]   recent_mean,
	input logic [Q_W-1:0]   overall_mean,
	input logic [CNT_W-1:0] stored_count
);

	logic [MIN_W-1:0] ms_q;

	// track the threshold the block should be using
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q <= MIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ms_q <= cfg_min_count;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	a_word_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(trend_ratio) && $stable(ready_res)
			&& $stable(recent_mean) && $stable(overall_mean) && $stable(stored_count))
		else $error("result word changed while stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 32'(stored_count) <= 32'(WINDOW_DEPTH))
		else $error("stored count beyond window depth");

	a_ready_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ready_res == (32'(stored_count) >= 32'(ms_q)))
		else $error("ready flag disagrees with count and threshold");

	a_trend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !ready_res |-> trend_ratio == ONE_Q16)
		else $error("trend not 1.0 before ready");

endmodule

bind windowed_loss_trend_tracker wltt_check #(
	.WINDOW_DEPTH(WINDOW_DEPTH),
	.CNT_W(CNT_W)
) u_wltt_check (
	.clk(clk),
	.arst_n(arst_n),
	.cfg_valid(cfg.valid),
	.cfg_ready(cfg.ready),
	.cfg_min_count(cfg.min_count),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.trend_ratio(result.trend_ratio),
	.ready_res(result.ready_res),
	.recent_mean(result.recent_mean),
	.overall_mean(result.overall_mean),
	.stored_count(result.stored_count)
);
